>>> rtl/json_string_unescape_utf8_macros.svh
// Assertion macros for the JSON string unescaper checker.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// property that must hold on every cycle out of reset
`define JSU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("jsu check failed");

// antecedent in one cycle implies consequent in the next
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu check failed");

`endif

>>> rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
// Used by the front decoder, the burst queue and the back serializer.
package jsu_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // result status codes
  localparam logic [1:0] ST_BYTE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // one decoded event: up to four UTF-8 bytes, a finish, or an error
  typedef struct packed {
    logic [1:0]             status;
    logic [1:0]             nm1;     // number of results minus one
    logic [3:0][7:0]        bytes;   // bytes[0] goes out first
    logic [LENGTH_BITS-1:0] length;
  } burst_t;

endpackage

>>> rtl/json_string_unescape_utf8.sv
// JSON string body unescaper with UTF-8 output. Feed the bytes after the
// opening quote, one per transfer on the slave side; the block accepts one
// byte per cycle while its queue has room and sends one result per cycle on
// the master side unless stalled. The front decoder drops its results into a
// four-entry burst queue; the back stage drains it one result per cycle
// unless stalled, so a \u escape that expands to three or four UTF-8 bytes
// holds the input off only once the queue has filled. Escape bytes other
// than the last of a sequence give no result. A closing quote gives a finish
// result with the byte count, malformed input an error result; either one
// restarts the decoder. Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
module json_string_unescape_utf8 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] at_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_byte, [31:8] decoded_length
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast    // last
);

  jsu_pkg::burst_t push_data, head;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  logic [7:0]      out_byte;
  logic [jsu_pkg::LENGTH_BITS-1:0] out_length;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .in_end    (s_tuser[0]),
    .q_full    (q_full),
    .in_ready  (s_tready),
    .push      (q_push),
    .push_data (push_data)
  );

  jsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (out_byte),
    .out_status  (m_tuser),
    .out_length  (out_length),
    .out_last    (m_tlast)
  );

  assign m_tdata = {out_length, out_byte};

endmodule

>>> rtl/jsu_queue.sv
// Short FIFO of decoded bursts between the front decoder and back serializer.
// Depends on jsu_pkg.
module jsu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jsu_pkg::burst_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output jsu_pkg::burst_t head
);

  jsu_pkg::burst_t             mem [jsu_pkg::QUEUE_DEPTH];
  logic [jsu_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [jsu_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [jsu_pkg::QUEUE_AW:0]   count;

  assign full      = (count == (jsu_pkg::QUEUE_AW+1)'(jsu_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/jsu_front.sv
// Front decoder: accepts string body bytes, tracks escape state and length,
// and turns each byte into at most one burst for the queue. Depends on jsu_pkg.
module jsu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  input  logic            q_full,
  output logic            in_ready,
  output logic            push,
  output jsu_pkg::burst_t push_data
);

  localparam logic [2:0] M_PLAIN   = 3'd0;
  localparam logic [2:0] M_ESC     = 3'd1;
  localparam logic [2:0] M_HEX     = 3'd2;
  localparam logic [2:0] M_LOW_BS  = 3'd3;
  localparam logic [2:0] M_LOW_U   = 3'd4;
  localparam logic [2:0] M_LOW_HEX = 3'd5;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic [2:0]                     mode, mode_next;
  logic [15:0]                    acc, acc_next;
  logic [1:0]                     cnt, cnt_next;
  logic [9:0]                     hs, hs_next;
  logic [jsu_pkg::LENGTH_BITS-1:0] len, len_next;

  logic            take;
  logic            fail, emit;
  jsu_pkg::burst_t enc;
  logic [4:0]      hexd;
  logic [15:0]     acc_shift;
  logic [20:0]     cp;
  logic [jsu_pkg::LENGTH_BITS:0] len_sum;

  // {invalid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39)      r = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
    return r;
  endfunction

  function automatic jsu_pkg::burst_t utf8_encode(input logic [20:0] c);
    jsu_pkg::burst_t r;
    r = '0;
    r.status = jsu_pkg::ST_BYTE;
    if (c < 21'h80) begin
      r.nm1      = 2'd0;
      r.bytes[0] = c[7:0];
    end else if (c < 21'h800) begin
      r.nm1      = 2'd1;
      r.bytes[0] = {3'b110, c[10:6]};
      r.bytes[1] = {2'b10, c[5:0]};
    end else if (c < 21'h10000) begin
      r.nm1      = 2'd2;
      r.bytes[0] = {4'b1110, c[15:12]};
      r.bytes[1] = {2'b10, c[11:6]};
      r.bytes[2] = {2'b10, c[5:0]};
    end else begin
      r.nm1      = 2'd3;
      r.bytes[0] = {5'b11110, c[20:18]};
      r.bytes[1] = {2'b10, c[17:12]};
      r.bytes[2] = {2'b10, c[11:6]};
      r.bytes[3] = {2'b10, c[5:0]};
    end
    return r;
  endfunction

  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;
  assign hexd      = hex_decode(in_byte);
  assign acc_shift = {acc[11:0], hexd[3:0]};

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    cnt_next  = cnt;
    hs_next   = hs;
    len_next  = len;
    push      = 1'b0;
    push_data = '0;
    fail      = 1'b0;
    emit      = 1'b0;
    enc       = '0;
    cp        = '0;
    len_sum   = '0;

    if (in_end) begin
      fail = 1'b1;
    end else begin
      case (mode)
        M_PLAIN: begin
          if (in_byte == CH_QUOTE) begin
            push             = 1'b1;
            push_data.status = jsu_pkg::ST_DONE;
            push_data.length = len;
            mode_next        = M_PLAIN;
            acc_next         = '0;
            cnt_next         = '0;
            hs_next          = '0;
            len_next         = '0;
          end else if (in_byte == CH_BSL) begin
            mode_next = M_ESC;
          end else if (in_byte < CH_SPACE) begin
            fail = 1'b1;
          end else begin
            emit         = 1'b1;
            enc.bytes[0] = in_byte;
          end
        end
        M_ESC: begin
          case (in_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: begin
              emit = 1'b1; enc.bytes[0] = in_byte;
            end
            8'h62: begin emit = 1'b1; enc.bytes[0] = 8'h08; end
            8'h66: begin emit = 1'b1; enc.bytes[0] = 8'h0C; end
            8'h6E: begin emit = 1'b1; enc.bytes[0] = 8'h0A; end
            8'h72: begin emit = 1'b1; enc.bytes[0] = 8'h0D; end
            8'h74: begin emit = 1'b1; enc.bytes[0] = 8'h09; end
            8'h75: begin
              mode_next = M_HEX;
              acc_next  = '0;
              cnt_next  = '0;
            end
            default: fail = 1'b1;
          endcase
        end
        M_HEX, M_LOW_HEX: begin
          if (hexd[4]) begin
            fail = 1'b1;
          end else begin
            acc_next = acc_shift;
            if (cnt != 2'd3) begin
              cnt_next = cnt + 2'd1;
            end else begin
              cnt_next = '0;
              if (mode == M_HEX) begin
                if (acc_shift[15:10] == 6'b110110) begin
                  hs_next   = acc_shift[9:0];
                  mode_next = M_LOW_BS;
                end else if (acc_shift[15:10] == 6'b110111) begin
                  fail = 1'b1;
                end else begin
                  emit = 1'b1;
                  cp   = {5'b0, acc_shift};
                  enc  = utf8_encode(cp);
                end
              end else if (acc_shift[15:10] != 6'b110111) begin
                fail = 1'b1;
              end else begin
                // 0x10000 + (high << 10) + low bits
                emit = 1'b1;
                cp   = {11'(hs) + 11'h040, acc_shift[9:0]};
                enc  = utf8_encode(cp);
              end
            end
          end
        end
        M_LOW_BS: begin
          if (in_byte != CH_BSL) fail = 1'b1;
          else mode_next = M_LOW_U;
        end
        M_LOW_U: begin
          if (in_byte != 8'h75) begin
            fail = 1'b1;
          end else begin
            mode_next = M_LOW_HEX;
            acc_next  = '0;
            cnt_next  = '0;
          end
        end
        default: fail = 1'b1;
      endcase
    end

    if (fail) begin
      push             = 1'b1;
      push_data        = '0;
      push_data.status = jsu_pkg::ST_ERR;
      mode_next        = M_PLAIN;
      acc_next         = '0;
      cnt_next         = '0;
      hs_next          = '0;
      len_next         = '0;
    end else if (emit) begin
      push      = 1'b1;
      push_data = enc;
      mode_next = M_PLAIN;
      len_sum   = {1'b0, len} + (jsu_pkg::LENGTH_BITS+1)'(enc.nm1) + 1'b1;
      len_next  = len_sum[jsu_pkg::LENGTH_BITS] ? '1 : len_sum[jsu_pkg::LENGTH_BITS-1:0];
    end

    push = push && take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_PLAIN;
      acc  <= '0;
      cnt  <= '0;
      hs   <= '0;
      len  <= '0;
    end else if (take) begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
      hs   <= hs_next;
      len  <= len_next;
    end
  end

endmodule

>>> rtl/jsu_back.sv
// Back serializer: walks the queue head into a registered output
// stage, one result per cycle unless stalled. Depends on jsu_pkg.
module jsu_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_not_empty,
  input  jsu_pkg::burst_t                 head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic [1:0]                      out_status,
  output logic [jsu_pkg::LENGTH_BITS-1:0] out_length,
  output logic                            out_last
);

  logic [1:0] pos;
  logic       load;
  logic       at_tail;

  assign load    = q_not_empty && (!out_valid || out_ready);
  assign at_tail = (pos == head.nm1);
  assign pop     = load && at_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= at_tail ? 2'd0 : pos + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= head.bytes[pos];
      out_status <= head.status;
      out_length <= head.length;
      out_last   <= at_tail;
    end
  end

endmodule

>>> rtl/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescape_utf8_macros.svh.
`include "json_string_unescape_utf8_macros.svh"

module jsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  logic data_res;
  assign data_res = m_tvalid && (m_tuser == jsu_pkg::ST_BYTE);

  // finish and error results always close the output of their input byte
  `JSU_ASSERT(a_end_is_last, !(m_tvalid && !data_res) || m_tlast)
  // byte results carry no length
  `JSU_ASSERT(a_byte_no_len, !data_res || (m_tdata[31:8] == 24'd0))
  // finish and error results carry no byte
  `JSU_ASSERT(a_end_no_byte, !(m_tvalid && !data_res) || (m_tdata[7:0] == 8'd0))
  // a stalled result holds
  `JSU_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

>>> test/json_string_unescape_utf8_tb.sv
// Self-checking testbench for json_string_unescape_utf8: drives string bodies byte by byte
// and checks every decoded byte, finish and error transfer against a built-in predictor.
// Depends on jsu_pkg and the json_string_unescape_utf8 RTL.
`timescale 1ns / 1ps

module json_string_unescape_utf8_tb;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  localparam logic [15:0] HI_SURR_MIN = 16'hD800;
  localparam logic [15:0] HI_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SURR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SURR_MAX = 16'hDFFF;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [23:0] length;
    logic        last;
  } result_t;

  class unescape_check;
    typedef enum logic [2:0] {
      IN_TEXT, AFTER_BSLASH, IN_HEX, WANT_LOW_BSLASH, WANT_LOW_U, IN_LOW_HEX
    } mode_t;

    mode_t                           mode;
    logic [15:0]                     hex_acc;
    logic [1:0]                      digit_cnt;
    logic [9:0]                      high_bits;
    logic [jsu_pkg::LENGTH_BITS-1:0] byte_count;
    result_t                         burst[$];
    result_t                         awaited[$];
    int mismatches, bytes_seen, strings_done, strings_bad;

    function new();
      restart();
    endfunction

    static function bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
      v = 4'd0;
      if (b >= CH_0 && b <= CH_9) v = 4'(b - CH_0);
      else if (b >= CH_LA && b <= CH_LF) v = 4'(b - CH_LA + 8'd10);
      else if (b >= CH_UA && b <= CH_UF) v = 4'(b - CH_UA + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function void restart();
      mode       = IN_TEXT;
      hex_acc    = '0;
      digit_cnt  = '0;
      high_bits  = '0;
      byte_count = '0;
    endfunction

    function void put_byte(logic [7:0] b);
      result_t r;
      r = '{b, jsu_pkg::ST_BYTE, 24'd0, 1'b0};
      burst.insert(burst.size(), r);
      if (byte_count != '1) byte_count++;
    endfunction

    function void put_code_point(logic [20:0] cp);
      if (cp < 21'h80) begin
        put_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end else begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
      mode = IN_TEXT;
    endfunction

    function void put_error();
      result_t r;
      r = '{8'd0, jsu_pkg::ST_ERR, 24'd0, 1'b0};
      burst.insert(burst.size(), r);
      restart();
    endfunction

    function void put_done();
      logic [23:0] len;
      result_t     r;
      // reported length clamps at 24 bits on top of the counter's own saturation
      len = (byte_count > 24'hFFFFFF) ? 24'hFFFFFF : 24'(byte_count);
      r = '{8'd0, jsu_pkg::ST_DONE, len, 1'b0};
      burst.insert(burst.size(), r);
      restart();
    endfunction

    function void decode(logic [7:0] b);
      logic [3:0]  d;
      logic [7:0]  lit;
      logic [15:0] v;
      case (mode)
        IN_TEXT: begin
          if (b == CH_QUOTE) put_done();
          else if (b == CH_BSLASH) mode = AFTER_BSLASH;
          else if (b < CH_SPACE) put_error();
          else put_byte(b);
        end
        AFTER_BSLASH: begin
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: lit = b;
            CH_B: lit = 8'h08;
            CH_F: lit = 8'h0C;
            CH_N: lit = 8'h0A;
            CH_R: lit = 8'h0D;
            CH_T: lit = 8'h09;
            CH_U: begin
              mode = IN_HEX;
              hex_acc = '0;
              digit_cnt = '0;
              return;
            end
            default: begin
              put_error();
              return;
            end
          endcase
          mode = IN_TEXT;
          put_byte(lit);
        end
        IN_HEX, IN_LOW_HEX: begin
          if (!hex_nibble(b, d)) begin
            put_error();
            return;
          end
          hex_acc = {hex_acc[11:0], d};
          if (digit_cnt < 2'd3) begin
            digit_cnt++;
            return;
          end
          digit_cnt = '0;
          v = hex_acc;
          if (mode == IN_HEX) begin
            if (v >= HI_SURR_MIN && v <= HI_SURR_MAX) begin
              high_bits = v[9:0];
              mode = WANT_LOW_BSLASH;
            end else if (v >= LO_SURR_MIN && v <= LO_SURR_MAX) begin
              put_error();
            end else begin
              put_code_point({5'd0, v});
            end
          end else if (v < LO_SURR_MIN || v > LO_SURR_MAX) begin
            put_error();
          end else begin
            put_code_point(21'h10000 + {high_bits, v[9:0]});
          end
        end
        WANT_LOW_BSLASH: begin
          if (b != CH_BSLASH) put_error();
          else mode = WANT_LOW_U;
        end
        WANT_LOW_U: begin
          if (b != CH_U) begin
            put_error();
          end else begin
            mode = IN_LOW_HEX;
            hex_acc = '0;
            digit_cnt = '0;
          end
        end
        default: put_error();
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic at_end);
      burst.delete();
      if (at_end) put_error();
      else decode(b);
      if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
      awaited = {awaited, burst};
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    function void check_output(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result: byte %02h status %0d length %0d last %0d",
                       got.out_byte, got.status, got.length, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        flag($sformatf({"mismatch: expected byte %02h status %0d length %0d last %0d,",
                        " got byte %02h status %0d length %0d last %0d"},
                       want.out_byte, want.status, want.length, want.last,
                       got.out_byte, got.status, got.length, got.last));
      end
      case (want.status)
        jsu_pkg::ST_BYTE: bytes_seen++;
        jsu_pkg::ST_DONE: strings_done++;
        default: strings_bad++;
      endcase
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
  logic [0:0]  s_tuser = 1'b0;   // [0] at_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [7:0] out_byte, [31:8] decoded_length
  logic [1:0]  m_tuser;          // [1:0] status
  logic        m_tlast;

  unescape_check sb = new();
  int items_sent = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  json_string_unescape_utf8 DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // input and output transfers are scored in one place so order within an edge is fixed
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready)
        sb.check_output('{m_tdata[7:0], m_tuser, m_tdata[31:8], m_tlast});
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, sb.awaited.size());
        $display("FAIL json_string_unescape_utf8");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send(input logic [7:0] b, input logic at_end);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= at_end;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(0, 7))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] b);
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_u(input logic [15:0] v);
    send(CH_BSLASH, 1'b0);
    send(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) send(hex_char(v[i*4 +: 4]), 1'b0);
  endtask

  task automatic send_string();
    logic [15:0] v;
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send(text_char(), 1'b0);
        4, 5: begin
          send(CH_BSLASH, 1'b0);
          send(simple_escape(), 1'b0);
        end
        6: send_u(16'($urandom_range(0, 16'h7F)));
        7: send_u(16'($urandom_range(16'h80, 16'h7FF)));
        8: begin
          do v = 16'($urandom_range(16'h800, 16'hFFFF));
          while (v >= HI_SURR_MIN && v <= LO_SURR_MAX);
          send_u(v);
        end
        default: begin
          send_u(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
          send_u(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
        end
      endcase
    end
    send(CH_QUOTE, 1'b0);
  endtask

  task automatic send_broken();
    logic [7:0]  b;
    logic [3:0]  d;
    logic [15:0] v;
    case ($urandom_range(0, 6))
      0: repeat ($urandom_range(1, 6)) send(8'($urandom_range(0, 255)), 1'b0);
      1: begin
        repeat ($urandom_range(0, 3)) send(text_char(), 1'b0);
        send(8'($urandom_range(0, 255)), 1'b1);
      end
      2: begin
        send(CH_BSLASH, 1'b0);
        do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
        send(b, 1'b0);
      end
      3: begin
        send(CH_BSLASH, 1'b0);
        send(CH_U, 1'b0);
        repeat ($urandom_range(0, 3)) send(hex_char(4'($urandom_range(0, 15))), 1'b0);
        do b = 8'($urandom_range(0, 255)); while (unescape_check::hex_nibble(b, d));
        send(b, 1'b0);
      end
      4: send_u(16'($urandom_range(LO_SURR_MIN, LO_SURR_MAX)));
      5: begin
        // high surrogate whose low half goes wrong at some point
        send_u(16'($urandom_range(HI_SURR_MIN, HI_SURR_MAX)));
        case ($urandom_range(0, 3))
          0: begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
            send(b, 1'b0);
          end
          1: begin
            send(CH_BSLASH, 1'b0);
            do b = 8'($urandom_range(0, 255)); while (b == CH_U);
            send(b, 1'b0);
          end
          2: begin
            do v = 16'($urandom_range(0, 16'hFFFF));
            while (v >= LO_SURR_MIN && v <= LO_SURR_MAX);
            send_u(v);
          end
          default: send(8'($urandom_range(0, 255)), 1'b1);
        endcase
      end
      default: begin
        repeat ($urandom_range(0, 3)) send(text_char(), 1'b0);
        send(8'($urandom_range(0, 31)), 1'b0);
      end
    endcase
  endtask

  initial begin
    bit hold_done, drain_done;
    int start_count;
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(CH_QUOTE, 1'b0);          // empty string
    send(8'hFF, 1'b0);
    send(CH_SPACE, 1'b0);
    send(8'h1F, 1'b0);             // raw control byte
    send_u(16'h0000);              // escaped NUL
    send(CH_QUOTE, 1'b0);
    send(CH_BSLASH, 1'b0);         // unknown escape
    send(8'h71, 1'b0);
    send(8'hFF, 1'b1);             // end of input
    send_u(LO_SURR_MAX);           // lone low surrogate
    send(CH_BSLASH, 1'b0);         // bad hex digit
    send(CH_U, 1'b0);
    send(8'h47, 1'b0);

    start_count = items_sent;
    while (items_sent < start_count + RANDOM_ITEMS) begin
      if (!hold_done && items_sent > start_count + 120) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent > start_count + 240) begin
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        drain_done = 1'b1;
      end
      if (items_sent > start_count + 320) idle_on = 1'b0;
      if ($urandom_range(0, 3) != 0) send_string();
      else send_broken();
    end
    s_tvalid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.awaited.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.awaited.size()));

    $display("covered %0d input bytes: %0d decoded bytes, %0d finished strings, %0d errors",
             items_sent, sb.bytes_seen, sb.strings_done, sb.strings_bad);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS json_string_unescape_utf8");
    end else begin
      $display("FAIL json_string_unescape_utf8");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_queue.sv
rtl/jsu_front.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
rtl/jsu_checker.sv
test/json_string_unescape_utf8_tb.sv
